FILE: sv/fpa_pkg.sv
package fpa_pkg;

    // Store geometry and address layout.
    localparam int MAX_PAGES  = 1024;
    localparam int PAGE_SHIFT = 12;
    localparam int ADDR_BITS  = 56;
    localparam int PAGE_AW    = $clog2(MAX_PAGES);
    localparam int CNT_W      = $clog2(MAX_PAGES + 1);
    localparam int FLAG_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;

    // Per-page flag bits.
    localparam logic [FLAG_W-1:0] FLAG_USED = 2'b01;
    localparam logic [FLAG_W-1:0] FLAG_LAST = 2'b10;

    // Request types.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BADFREE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_PAGES  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_BASE = 1'b1;

    // Datapath operations issued by the controller, one per cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ACCEPT,
        OP_SCAN,
        OP_MARK,
        OP_CHECK,
        OP_RD_CUR,
        OP_RD_PREV,
        OP_RD_PAGE,
        OP_WIPE,
        OP_RESULT
    } fpa_op_t;

    typedef struct packed {
        fpa_op_t             op;
        logic [STATUS_W-1:0] code;
    } fpa_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic count_bad;
        logic found;
        logic exhausted;
        logic mark_done;
        logic addr_bad;
        logic rd_used;
        logic rd_last;
        logic first_zero;
        logic wipe_end;
    } fpa_stat_t;

endpackage

FILE: sv/fpa_ram.sv
module fpa_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/fpa_dp.sv
module fpa_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [fpa_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [fpa_pkg::ADDR_BITS-1:0]       cfg_data,
    input  logic                                req_type,
    input  logic [fpa_pkg::CNT_W-1:0]           page_count,
    input  logic [fpa_pkg::ADDR_BITS-1:0]       free_address,
    input  fpa_pkg::fpa_cmd_t                   cmd,
    output fpa_pkg::fpa_stat_t                  stat,
    output logic [fpa_pkg::STATUS_W-1:0]        status,
    output logic [fpa_pkg::ADDR_BITS-1:0]       run_address,
    output logic [fpa_pkg::PAGE_AW-1:0]         first_page
);

    import fpa_pkg::*;

    localparam int HI_W = ADDR_BITS - PAGE_SHIFT;

    logic [CNT_W-1:0]     num_pages_reg;
    logic [ADDR_BITS-1:0] base_reg;
    logic                 type_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [CNT_W-1:0]     n_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic [CNT_W-1:0]     len_reg;
    logic [CNT_W-1:0]     pidx_reg;
    logic                 pend_reg;
    logic [CNT_W-1:0]     start_reg;
    logic [CNT_W-1:0]     last_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [ADDR_BITS-1:0] run_addr_reg;
    logic [PAGE_AW-1:0]   first_reg;

    logic [CNT_W-1:0]     managed;
    logic [ADDR_BITS:0]   diff_full;
    logic [HI_W-1:0]      page_hi;
    logic [CNT_W-1:0]     len_inc;
    logic [CNT_W-1:0]     start_calc;
    logic                 found;

    logic                 ram_we;
    logic [PAGE_AW-1:0]   ram_waddr;
    logic [FLAG_W-1:0]    ram_wdata;
    logic                 ram_re;
    logic [PAGE_AW-1:0]   ram_raddr;
    logic [FLAG_W-1:0]    ram_rdata;

    always_comb
    begin
        managed = (num_pages_reg > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : num_pages_reg;
        diff_full  = {1'b0, addr_reg} - {1'b0, base_reg};
        page_hi    = diff_full[ADDR_BITS-1:PAGE_SHIFT];
        len_inc    = len_reg + CNT_W'(1);
        start_calc = pidx_reg + CNT_W'(1) - count_reg;
        found      = pend_reg && ((ram_rdata & FLAG_USED) == '0) && (len_inc == count_reg);

        stat.clear_done = (idx_reg == CNT_W'(MAX_PAGES - 1));
        stat.count_bad  = (count_reg == '0) || (count_reg > n_reg);
        stat.found      = found;
        stat.exhausted  = pend_reg && !found && (pidx_reg == n_reg - CNT_W'(1));
        stat.mark_done  = (idx_reg == last_reg);
        stat.addr_bad   = diff_full[ADDR_BITS]
                          || (diff_full[PAGE_SHIFT-1:0] != '0)
                          || (page_hi >= HI_W'(n_reg));
        stat.rd_used    = ((ram_rdata & FLAG_USED) != '0);
        stat.rd_last    = ((ram_rdata & FLAG_LAST) != '0);
        stat.first_zero = (idx_reg == '0);
        stat.wipe_end   = (idx_reg == n_reg - CNT_W'(1));

        ram_we    = cmd.op inside {OP_CLEAR, OP_MARK, OP_WIPE};
        ram_waddr = idx_reg[PAGE_AW-1:0];
        ram_wdata = '0;
        if (cmd.op == OP_MARK)
        begin
            ram_wdata = (idx_reg == last_reg) ? (FLAG_USED | FLAG_LAST) : FLAG_USED;
        end
        ram_re    = cmd.op inside {OP_SCAN, OP_RD_CUR, OP_RD_PREV, OP_RD_PAGE};
        ram_raddr = (cmd.op == OP_RD_PREV) ? (idx_reg[PAGE_AW-1:0] - PAGE_AW'(1))
                                           : idx_reg[PAGE_AW-1:0];
    end

    // Control registers and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_pages_reg <= CNT_W'(MAX_PAGES);
            base_reg      <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_NUM_PAGES:  num_pages_reg <= cfg_data[CNT_W-1:0];
                    CFG_ALLOC_BASE: base_reg      <= cfg_data;
                    default:        ;
                endcase
            end
            case (cmd.op)
                OP_CLEAR, OP_MARK, OP_WIPE:
                begin
                    idx_reg <= idx_reg + CNT_W'(1);
                end
                OP_ACCEPT:
                begin
                    idx_reg  <= '0;
                    pend_reg <= 1'b0;
                end
                OP_SCAN:
                begin
                    pend_reg <= (idx_reg < n_reg);
                    idx_reg  <= found ? start_calc : (idx_reg + CNT_W'(1));
                end
                OP_CHECK:
                begin
                    idx_reg <= page_hi[CNT_W-1:0];
                end
                default: ;
            endcase
        end
    end

    // Request and result payload.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_ACCEPT:
            begin
                type_reg  <= req_type;
                count_reg <= page_count;
                addr_reg  <= free_address;
                n_reg     <= managed;
                len_reg   <= '0;
            end
            OP_SCAN:
            begin
                pidx_reg <= idx_reg;
                if (pend_reg)
                begin
                    len_reg <= stat.rd_used ? '0 : len_inc;
                end
                if (found)
                begin
                    start_reg <= start_calc;
                    last_reg  <= pidx_reg;
                end
            end
            OP_CHECK:
            begin
                start_reg <= page_hi[CNT_W-1:0];
            end
            OP_RESULT:
            begin
                status_reg   <= cmd.code;
                run_addr_reg <= (cmd.code == ST_OK && type_reg == REQ_ALLOC)
                                ? base_reg + (ADDR_BITS'(start_reg) << PAGE_SHIFT) : '0;
                first_reg    <= (cmd.code == ST_OK) ? start_reg[PAGE_AW-1:0] : '0;
            end
            default: ;
        endcase
    end

    fpa_ram #(
        .WIDTH (FLAG_W),
        .DEPTH (MAX_PAGES)
    ) u_flags (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign status      = status_reg;
    assign run_address = run_addr_reg;
    assign first_page  = first_reg;

endmodule

FILE: sv/fpa_ctrl.sv
module fpa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               req_type,
    output logic               in_stall,
    output logic               out_valid,
    input  logic               out_stall,
    input  fpa_pkg::fpa_stat_t stat,
    output fpa_pkg::fpa_cmd_t  cmd
);

    import fpa_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ACHK,
        S_SCAN,
        S_MARK,
        S_FCHK,
        S_RDCUR,
        S_RDPREV,
        S_PCHK,
        S_WRD,
        S_WWR,
        S_RESULT
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [STATUS_W-1:0] code_reg;
    logic [STATUS_W-1:0] code_next;
    logic                out_valid_reg;
    logic                out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        code_next      = code_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd.op         = OP_NONE;
        cmd.code       = code_reg;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = OP_ACCEPT;
                    state_next = (req_type == REQ_FREE) ? S_FCHK : S_ACHK;
                end
            end
            S_ACHK:
            begin
                if (stat.count_bad)
                begin
                    code_next  = ST_NOFIT;
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.op = OP_SCAN;
                if (stat.found)
                begin
                    state_next = S_MARK;
                end
                else if (stat.exhausted)
                begin
                    code_next  = ST_NOFIT;
                    state_next = S_RESULT;
                end
            end
            S_MARK:
            begin
                cmd.op = OP_MARK;
                if (stat.mark_done)
                begin
                    code_next  = ST_OK;
                    state_next = S_RESULT;
                end
            end
            S_FCHK:
            begin
                cmd.op = OP_CHECK;
                if (stat.addr_bad)
                begin
                    code_next  = ST_BADFREE;
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_RDCUR;
                end
            end
            S_RDCUR:
            begin
                cmd.op     = OP_RD_CUR;
                state_next = S_RDPREV;
            end
            S_RDPREV:
            begin
                if (!stat.rd_used)
                begin
                    code_next  = ST_BADFREE;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.op     = OP_RD_PREV;
                    state_next = S_PCHK;
                end
            end
            S_PCHK:
            begin
                if (!stat.first_zero && stat.rd_used && !stat.rd_last)
                begin
                    code_next  = ST_BADFREE;
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_WRD;
                end
            end
            S_WRD:
            begin
                cmd.op     = OP_RD_PAGE;
                state_next = S_WWR;
            end
            S_WWR:
            begin
                cmd.op = OP_WIPE;
                if (stat.rd_last || stat.wipe_end)
                begin
                    code_next  = ST_OK;
                    state_next = S_RESULT;
                end
                else
                begin
                    state_next = S_WRD;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.op         = OP_RESULT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            code_reg      <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            code_reg      <= code_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: sv/first_fit_page_allocator_top.sv
// Channel   Handshake             Payload
// -------   -------------------   ------------------------------------------
// input     in_valid / in_stall   req_type, page_count, free_address
// output    out_valid / out_stall status, run_address, first_page
// config    cfg_write             cfg_index, cfg_data (no handshake back)
//
// In an allocate (n managed pages) one page a cycle is scanned up to the end of the
// first fitting run, then the run is marked one page a cycle.
// An allocate that finds no fitting run scans all n pages.
// A free reads and then wipes each page of the run; a bad count or free ends early.
// After reset a pass clearing the flag memory holds in_stall high; config writes are taken.
// One transaction is in flight; a new result waits only while the previous one is stalled.

module first_fit_page_allocator_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 req_type,
    input  logic [fpa_pkg::CNT_W-1:0]            page_count,
    input  logic [fpa_pkg::ADDR_BITS-1:0]        free_address,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [fpa_pkg::STATUS_W-1:0]         status,
    output logic [fpa_pkg::ADDR_BITS-1:0]        run_address,
    output logic [fpa_pkg::PAGE_AW-1:0]          first_page,
    input  logic                                 cfg_write,
    input  logic [fpa_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [fpa_pkg::ADDR_BITS-1:0]        cfg_data
);

    import fpa_pkg::*;

    fpa_cmd_t  cmd;
    fpa_stat_t stat;

    // The controller sequences each transaction; the datapath owns the flag
    // memory, the scan and clear counters and the result registers.
    fpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .req_type  (req_type),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    fpa_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .req_type     (req_type),
        .page_count   (page_count),
        .free_address (free_address),
        .cmd          (cmd),
        .stat         (stat),
        .status       (status),
        .run_address  (run_address),
        .first_page   (first_page)
    );

    // An accepted transaction makes the block busy on the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("block not busy after accepting a transaction");

    // Loading the result register always presents a result.
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_RESULT) |=> out_valid)
        else $error("result loaded but not presented");

    // A failed transaction carries neither an address nor a page number.
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK) |-> (run_address == '0 && first_page == '0))
        else $error("failed result carries address or page");

    // A run found by the scan is marked straight away.
    a_found_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_SCAN && stat.found) |=> (cmd.op == OP_MARK))
        else $error("found run not marked");

endmodule
